/* hw/rtl/u32u16_pkg.sv */
package u32u16_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        is_error;
        logic        last_unit;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_BARE,
        KIND_REPL,
        KIND_UNIT,
        KIND_PAIR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [20:0] point;
        logic        last;
    } t_word;

    localparam logic [2:0] MODE_BIG         = 3'd0;
    localparam logic [2:0] MODE_LITTLE      = 3'd1;
    localparam logic [2:0] MODE_AUTO        = 3'd2;
    localparam logic [2:0] MODE_BIG_DROP    = 3'd3;
    localparam logic [2:0] MODE_LITTLE_DROP = 3'd4;

    localparam logic [31:0] MAX_POINT   = 32'h0010_FFFF;
    localparam logic [31:0] SURR_LO     = 32'h0000_D800;
    localparam logic [31:0] SURR_HI     = 32'h0000_DFFF;
    localparam logic [31:0] BOM_POINT   = 32'h0000_FEFF;
    localparam logic [31:0] BOM_LE_SEEN = 32'hFFFE_0000;
    localparam logic [31:0] BMP_MAX     = 32'h0000_FFFF;
    localparam logic [20:0] PLANE1_BASE = 21'h01_0000;
    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [5:0]  HIGH_TAG    = 6'b110110;
    localparam logic [5:0]  LOW_TAG     = 6'b110111;

endpackage

/* hw/rtl/u32u16_front.sv */
module u32u16_front
    import u32u16_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_valid,
    input  logic [2:0] i_cfg_data,
    input  logic     i_take,
    input  t_in_item i_in,
    output logic     o_wr_en,
    output t_word    o_wr_data
);

    logic [2:0]  r_mode;
    logic [23:0] r_gather;
    logic [1:0]  r_count;
    logic        r_first;
    logic        r_little;

    logic [23:0] n_gather;
    logic [1:0]  n_count;
    logic        n_first;
    logic        n_little;

    logic [2:0]  mode;
    logic [31:0] be;
    logic [31:0] le;
    logic [31:0] cp;
    logic        mark_be;
    logic        mark_le;
    logic        little;
    logic        drop;
    logic        invalid;
    logic        word_done;

    always_comb begin
        mode = (r_mode > MODE_LITTLE_DROP) ? MODE_BIG : r_mode;
        be = {r_gather, i_in.data_byte};
        le = {i_in.data_byte, r_gather[7:0], r_gather[15:8], r_gather[23:16]};
        mark_be = (mode == MODE_AUTO) && r_first && (be == BOM_POINT);
        mark_le = (mode == MODE_AUTO) && r_first && (be == BOM_LE_SEEN);
        if (mode == MODE_AUTO) begin
            little = mark_le ? 1'b1 : (mark_be ? 1'b0 : r_little);
        end else begin
            little = (mode == MODE_LITTLE) || (mode == MODE_LITTLE_DROP);
        end
        cp = little ? le : be;
        drop = mark_be || mark_le
            || (((mode == MODE_BIG_DROP) || (mode == MODE_LITTLE_DROP))
                && r_first && (cp == BOM_POINT));
        invalid = (cp > MAX_POINT) || ((cp >= SURR_LO) && (cp <= SURR_HI));
        word_done = (r_count == 2'd3);

        o_wr_data.point = cp[20:0];
        o_wr_data.last  = i_in.last_byte;
        if (!word_done) begin
            o_wr_data.kind = KIND_REPL;
            o_wr_en = i_take && i_in.last_byte;
        end else if (drop) begin
            o_wr_data.kind = KIND_BARE;
            o_wr_en = i_take && i_in.last_byte;
        end else begin
            if (invalid) begin
                o_wr_data.kind = KIND_REPL;
            end else if (cp > BMP_MAX) begin
                o_wr_data.kind = KIND_PAIR;
            end else begin
                o_wr_data.kind = KIND_UNIT;
            end
            o_wr_en = i_take;
        end

        n_gather = r_gather;
        n_count  = r_count;
        n_first  = r_first;
        n_little = r_little;
        if (i_take) begin
            if (i_in.last_byte) begin
                n_gather = '0;
                n_count  = '0;
                n_first  = 1'b1;
                n_little = 1'b0;
            end else if (word_done) begin
                n_gather = '0;
                n_count  = '0;
                n_first  = 1'b0;
                if (mark_le) begin
                    n_little = 1'b1;
                end else if (mark_be) begin
                    n_little = 1'b0;
                end
            end else begin
                n_gather = {r_gather[15:0], i_in.data_byte};
                n_count  = r_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_BIG;
            r_gather <= '0;
            r_count  <= '0;
            r_first  <= 1'b1;
            r_little <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            r_gather <= n_gather;
            r_count  <= n_count;
            r_first  <= n_first;
            r_little <= n_little;
        end
    end

endmodule

/* hw/rtl/u32u16_queue.sv */
module u32u16_queue
    import u32u16_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_en,
    input  t_word i_wr_data,
    input  logic  i_rd_en,
    output t_word o_rd_data,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_word         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;

    logic do_wr;
    logic do_rd;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/u32u16_back.sv */
module u32u16_back
    import u32u16_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_word     i_word,
    input  logic      i_q_empty,
    output logic      o_q_rd,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_out
);

    logic        r_have;
    t_out_item   r_out;
    logic        r_pend;
    logic [15:0] r_low;
    logic        r_low_last;

    logic        load;
    logic [19:0] v;
    t_out_item   first;

    assign o_empty = !r_have;
    assign o_out   = r_out;
    assign load    = !r_have || i_pop;
    assign o_q_rd  = load && !r_pend && !i_q_empty;

    always_comb begin
        v = 20'(i_word.point - PLANE1_BASE);
        first = '0;
        unique case (i_word.kind)
            KIND_BARE: begin
                first.last_unit = 1'b1;
            end
            KIND_REPL: begin
                first.code_unit = REPL_UNIT;
                first.has_unit  = 1'b1;
                first.is_error  = 1'b1;
                first.last_unit = i_word.last;
            end
            KIND_UNIT: begin
                first.code_unit = i_word.point[15:0];
                first.has_unit  = 1'b1;
                first.last_unit = i_word.last;
            end
            KIND_PAIR: begin
                first.code_unit = {HIGH_TAG, v[19:10]};
                first.has_unit  = 1'b1;
            end
            default: begin
                first = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_out <= '{code_unit: r_low, has_unit: 1'b1, is_error: 1'b0,
                           last_unit: r_low_last};
            end else if (!i_q_empty) begin
                r_out      <= first;
                r_low      <= {LOW_TAG, v[9:0]};
                r_low_last <= i_word.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_pend <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_have <= 1'b1;
                r_pend <= 1'b0;
            end else if (!i_q_empty) begin
                r_have <= 1'b1;
                r_pend <= (i_word.kind == KIND_PAIR);
            end else begin
                r_have <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/utf32_to_utf16_transcoder_core.sv */
// Path: a result passes through the word queue and then the output register to the output.
// Throughput: one byte per cycle while the queue is not full; the output register gives one
// code unit per cycle while popped; a surrogate pair holds the result side, absorbed by the queue.
// Reset: synchronous, active low; clears mode, byte gather, queue and output valid flag.
// No clearing pass after reset; the block takes bytes on the first cycle out of reset.
module utf32_to_utf16_transcoder_core
    import u32u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] i_cfg_data,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_in,
    output logic       empty,
    input  logic       pop,
    output t_out_item  o_out
);

    logic  take;
    logic  q_wr;
    t_word q_wr_data;
    logic  q_rd;
    t_word q_rd_data;
    logic  q_full;
    logic  q_empty;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign take      = push && !q_full;

    u32u16_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_in        (i_in),
        .o_wr_en     (q_wr),
        .o_wr_data   (q_wr_data)
    );

    u32u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr),
        .i_wr_data (q_wr_data),
        .i_rd_en   (q_rd),
        .o_rd_data (q_rd_data),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    u32u16_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_word    (q_rd_data),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out.has_unit) |->
            (o_out.last_unit && !o_out.is_error && o_out.code_unit == 16'h0000))
        else $error("bare end marker malformed");

    a_error_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.is_error) |-> (o_out.code_unit == REPL_UNIT))
        else $error("error unit is not the replacement character");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_out.code_unit[15:10] == HIGH_TAG) |=>
            (!empty && o_out.code_unit[15:10] == LOW_TAG))
        else $error("high surrogate not followed by low surrogate");

    a_queue_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |-> take)
        else $error("queue written without a byte transfer");
`endif

endmodule
